// File: rtl/bpd_pkg.sv
package bpd_pkg;

   // Fixed Q8.16 datapath width
   localparam int DATA_WIDTH = 24;
   localparam int CFG_WIDTH  = 23;
   localparam int CORDIC_MAX = 24;
   localparam int ZW         = 34;   // CORDIC Q4.30 working width
   localparam int PW         = 49;   // shared multiplier product width

   localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic signed [ZW-1:0] CORDIC_K_Q30 = 34'sd652032874;

   // Register indexes
   typedef enum logic [2:0] {
      REG_PITCH_FAILSAFE = 3'd0,
      REG_PITCH_REF_LIM  = 3'd1,
      REG_VEL_GAIN       = 3'd2,
      REG_VEL_TRQ_LIM    = 3'd3,
      REG_GRAV_GAIN      = 3'd4,
      REG_DAMP_GAIN      = 3'd5,
      REG_PITCH_GAIN     = 3'd6,
      REG_FILTER_ALPHA   = 3'd7
   } reg_index_type;

   // Arctangent table, Q2.30
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

   // Saturate to the data width
   function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [ZW-1:0] v);
      logic signed [ZW-1:0] hi;
      logic signed [ZW-1:0] lo;
      begin
         hi = ZW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
         lo = -hi - ZW'(1);
         if (v > hi) return hi[DATA_WIDTH-1:0];
         else if (v < lo) return lo[DATA_WIDTH-1:0];
         else return v[DATA_WIDTH-1:0];
      end
   endfunction

   // Round half up from Q16 product and saturate
   function automatic logic signed [DATA_WIDTH-1:0] rnd_sat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      begin
         s = (p + PW'(32768)) >>> 16;
         return sat(s[ZW-1:0]);
      end
   endfunction

endpackage

// File: rtl/bpd_req_if.sv
interface bpd_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] pitch_meas;
   logic signed [23:0] pitch_rate_meas;
   logic signed [23:0] wheel_vel_meas;
   logic signed [23:0] pitch_target;
   logic signed [23:0] pitch_offset;
   logic signed [23:0] vel_target;
   logic               trust_update;
   logic               filter_restart;
   logic signed [23:0] filter_seed;

   modport source (output valid, pitch_meas, pitch_rate_meas, wheel_vel_meas, pitch_target,
                   pitch_offset, vel_target, trust_update, filter_restart, filter_seed,
                   input ready);
   modport sink (input valid, pitch_meas, pitch_rate_meas, wheel_vel_meas, pitch_target,
                 pitch_offset, vel_target, trust_update, filter_restart, filter_seed,
                 output ready);
endinterface

// File: rtl/bpd_rsp_if.sv
interface bpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] mech_torque;
   logic signed [23:0] error_torque;
   logic signed [23:0] vel_torque;
   logic signed [23:0] raw_torque;
   logic signed [23:0] filtered_torque;

   modport source (output valid, mech_torque, error_torque, vel_torque, raw_torque,
                   filtered_torque, input ready);
   modport sink (input valid, mech_torque, error_torque, vel_torque, raw_torque,
                 filtered_torque, output ready);
endinterface

// File: rtl/balance_pd_torque_lpf_top.sv
// Balance torque controller: PD law with gravity feedforward (CORDIC sine of the
// clamped pitch), pitch-rate damping, clamped pitch and velocity error terms, and a
// one-pole low-pass filter on the summed command. Each item passes a prep step, the
// iterative CORDIC loop, a sine step and then six products through one shared 24x24
// multiplier before the block is ready again. The result is registered in the last
// product step. The block takes one item at a time. A new item may be accepted while
// the previous result waits in the output register. A result that is still waiting
// stalls the next item in its last cycle.
module balance_pd_torque_lpf_top
   import bpd_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   bpd_req_if.sink              req,
   bpd_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata
);

   localparam int ITERS = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
   localparam int CW    = (ITERS > 1) ? $clog2(ITERS) : 1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_CORD = 5'b00100,
      S_SIN  = 5'b01000,
      S_MUL  = 5'b10000
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [16:0]          fsl_ff, alpha_ff;
   logic [CFG_WIDTH-1:0] rl_ff, vg_ff, vl_ff, gg_ff, dg_ff, pg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsl_ff   <= 17'd52429;
         rl_ff    <= 23'd19661;
         vg_ff    <= '0;
         vl_ff    <= 23'd65536;
         gg_ff    <= '0;
         dg_ff    <= '0;
         pg_ff    <= '0;
         alpha_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_PITCH_FAILSAFE: fsl_ff   <= csr_wdata[16:0];
            REG_PITCH_REF_LIM:  rl_ff    <= csr_wdata;
            REG_VEL_GAIN:       vg_ff    <= csr_wdata;
            REG_VEL_TRQ_LIM:    vl_ff    <= csr_wdata;
            REG_GRAV_GAIN:      gg_ff    <= csr_wdata;
            REG_DAMP_GAIN:      dg_ff    <= csr_wdata;
            REG_PITCH_GAIN:     pg_ff    <= csr_wdata;
            REG_FILTER_ALPHA:   alpha_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Captured item
   logic signed [23:0] pitch_ff, rate_ff, wheel_ff, tgt_ff, ofs_ff, vref_ff;
   logic               trust_ff;
   logic signed [23:0] fstate_ff;

   // Intermediates
   logic signed [23:0] perr_ff, verr_ff, sin_ff;
   logic signed [23:0] grav_ff, mech_ff, pterm_ff, vterm_ff, err_ff, raw_ff;
   logic signed [ZW-1:0] x_ff, y_ff, z_ff;
   logic [CW-1:0]        cnt_ff;
   logic [2:0]           k_ff;
   logic signed [PW-1:0] prod_ff, acc_ff;

   // Saturated limits
   logic [16:0] fs_lim, alpha_sat;
   assign fs_lim    = (fsl_ff > HALF_PI_Q16) ? HALF_PI_Q16 : fsl_ff;
   assign alpha_sat = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;

   // Prep arithmetic
   logic signed [24:0] fs_s, rl_s, tsum, ref_c, pitch_c;
   assign fs_s = $signed({8'd0, fs_lim});
   assign rl_s = $signed({2'd0, rl_ff});
   assign tsum = 25'(tgt_ff) + 25'(ofs_ff);
   assign ref_c = (tsum > rl_s) ? rl_s : ((tsum < -rl_s) ? -rl_s : tsum);
   assign pitch_c = (25'(pitch_ff) > fs_s) ? fs_s
                  : ((25'(pitch_ff) < -fs_s) ? -fs_s : 25'(pitch_ff));

   // CORDIC step
   logic signed [ZW-1:0] dx, dy, at;
   assign dx = y_ff >>> cnt_ff;
   assign dy = x_ff >>> cnt_ff;
   assign at = $signed({2'b00, atan_q30(5'(cnt_ff))});

   logic signed [ZW-1:0] sin_r;
   assign sin_r = (y_ff + ZW'(8192)) >>> 14;

   // Shared multiplier operand select
   logic [23:0]        op_a;
   logic signed [23:0] op_b;
   always_comb begin
      case (k_ff)
         3'd0: begin op_a = {1'b0, gg_ff}; op_b = sin_ff; end
         3'd1: begin op_a = {1'b0, dg_ff}; op_b = rate_ff; end
         3'd2: begin op_a = {1'b0, pg_ff}; op_b = perr_ff; end
         3'd3: begin op_a = {1'b0, vg_ff}; op_b = verr_ff; end
         3'd4: begin op_a = {7'd0, alpha_sat}; op_b = fstate_ff; end
         3'd6: begin op_a = {7'd0, 17'(ONE_Q16 - alpha_sat)}; op_b = raw_ff; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   logic signed [PW-1:0] mul_out;
   assign mul_out = $signed({1'b0, op_a}) * op_b;

   // Processing of the previous product
   logic signed [23:0] pr;
   assign pr = rnd_sat(prod_ff);

   logic signed [24:0] vl_s, vclamp;
   assign vl_s   = $signed({2'd0, vl_ff});
   assign vclamp = (25'(pr) > vl_s) ? vl_s : ((25'(pr) < -vl_s) ? -vl_s : 25'(pr));

   logic signed [PW-1:0] fsum;
   assign fsum = acc_ff + prod_ff;

   logic signed [23:0] u_val;
   assign u_val = rnd_sat(fsum);

   logic out_busy;
   assign out_busy = rsp.valid && !rsp.ready;

   assign req.ready = (state_ff == S_IDLE);

   // Sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp.valid <= 1'b0;
         fstate_ff <= '0;
         cnt_ff    <= '0;
         k_ff      <= '0;
      end else begin
         // the last product step loads a new result itself
         if (rsp.valid && rsp.ready && !(state_ff == S_MUL && k_ff == 3'd7))
            rsp.valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  pitch_ff <= req.pitch_meas;
                  rate_ff  <= req.pitch_rate_meas;
                  wheel_ff <= req.wheel_vel_meas;
                  tgt_ff   <= req.pitch_target;
                  ofs_ff   <= req.pitch_offset;
                  vref_ff  <= req.vel_target;
                  trust_ff <= req.trust_update;
                  if (req.filter_restart) fstate_ff <= req.filter_seed;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               perr_ff   <= sat(ZW'(ref_c) - ZW'(pitch_ff));
               verr_ff   <= sat(ZW'(vref_ff) - ZW'(wheel_ff));
               x_ff      <= CORDIC_K_Q30;
               y_ff      <= '0;
               z_ff      <= ZW'(pitch_c) <<< 14;
               cnt_ff    <= '0;
               state_ff  <= S_CORD;
            end
            S_CORD: begin
               if (!z_ff[ZW-1]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - at;
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + at;
               end
               if (cnt_ff == CW'(ITERS - 1)) state_ff <= S_SIN;
               else cnt_ff <= cnt_ff + CW'(1);
            end
            S_SIN: begin
               if (sin_r > ZW'(65536)) sin_ff <= 24'sd65536;
               else if (sin_r < -ZW'(65536)) sin_ff <= -24'sd65536;
               else sin_ff <= sin_r[23:0];
               k_ff     <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (!(k_ff == 3'd7 && out_busy)) begin
                  prod_ff <= mul_out;
                  k_ff    <= k_ff + 3'd1;
               end
               case (k_ff)
                  3'd1: grav_ff <= pr;
                  3'd2: mech_ff <= sat(-ZW'(grav_ff) - ZW'(pr));
                  3'd3: pterm_ff <= pr;
                  3'd4: begin
                     vterm_ff <= vclamp[23:0];
                     err_ff   <= sat(ZW'(pterm_ff) + ZW'(vclamp));
                  end
                  3'd5: begin
                     acc_ff <= prod_ff;
                     raw_ff <= sat(ZW'(mech_ff) + ZW'(err_ff));
                  end
                  3'd7: begin
                     if (!out_busy) begin
                        rsp.valid           <= 1'b1;
                        rsp.mech_torque     <= mech_ff;
                        rsp.error_torque    <= err_ff;
                        rsp.vel_torque      <= vterm_ff;
                        rsp.raw_torque      <= raw_ff;
                        rsp.filtered_torque <= u_val;
                        if (trust_ff) fstate_ff <= u_val;
                        state_ff <= S_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: test/bpd_torque_checker.sv
// Watches the item channels and the register port, predicts each torque result
// and compares it with what the block returns.
module bpd_torque_checker
   import bpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bpd_req_if          req,
   bpd_rsp_if          rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SINE_STEPS = 16;
   localparam longint SAT_HI = 64'sd8388607;
   localparam longint SAT_LO = -64'sd8388608;
   localparam longint GAIN_K_Q30 = 64'sd652032874;
   localparam longint LIM_HALF_PI = 64'sd102944;
   localparam longint UNITY_Q16 = 64'sd65536;

   typedef struct {
      longint mech;
      longint err;
      longint vel;
      longint raw;
      longint filt;
   } torque_set_t;

   localparam longint ATAN_Q30 [SINE_STEPS] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
   };

   // Shadow copies of the registers and the filter memory
   longint shadow_reg [8];
   longint lpf_mem;
   torque_set_t torque_queue [$];

   function automatic longint lim(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint sat24(longint v);
      return lim(v, SAT_LO, SAT_HI);
   endfunction

   // Round half up, arithmetic shift is a floor on longint
   function automatic longint rshift_round(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint gain_mul(longint gain, longint v);
      return sat24(rshift_round(gain * v, 16));
   endfunction

   function automatic longint sine_q16(longint ang);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = GAIN_K_Q30;
      y = 0;
      z = ang * 16384;
      for (int i = 0; i < SINE_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_Q30[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_Q30[i];
         end
      end
      return lim(rshift_round(y, 14), -UNITY_Q16, UNITY_Q16);
   endfunction

   // One control tick; updates the filter memory
   function automatic torque_set_t torque_predict(
      longint pitch, longint rate, longint wheel, longint target, longint offset,
      longint vref, logic trust, logic restart, longint seed);
      torque_set_t r;
      longint fs;
      longint rl;
      longint vl;
      longint alpha;
      longint grav;
      longint damp;
      longint pref;
      longint pterm;
      fs = (shadow_reg[REG_PITCH_FAILSAFE] > LIM_HALF_PI) ? LIM_HALF_PI
                                                          : shadow_reg[REG_PITCH_FAILSAFE];
      rl = shadow_reg[REG_PITCH_REF_LIM];
      vl = shadow_reg[REG_VEL_TRQ_LIM];
      alpha = (shadow_reg[REG_FILTER_ALPHA] > UNITY_Q16) ? UNITY_Q16
                                                         : shadow_reg[REG_FILTER_ALPHA];
      grav = gain_mul(shadow_reg[REG_GRAV_GAIN], sine_q16(lim(pitch, -fs, fs)));
      damp = gain_mul(shadow_reg[REG_DAMP_GAIN], rate);
      r.mech = sat24(-grav - damp);
      pref = sat24(lim(target + offset, -rl, rl));
      pterm = gain_mul(shadow_reg[REG_PITCH_GAIN], sat24(pref - pitch));
      r.vel = sat24(lim(gain_mul(shadow_reg[REG_VEL_GAIN], sat24(vref - wheel)), -vl, vl));
      r.err = sat24(pterm + r.vel);
      r.raw = sat24(r.mech + r.err);
      if (restart) lpf_mem = seed;
      r.filt = sat24(rshift_round(alpha * lpf_mem + (UNITY_Q16 - alpha) * r.raw, 16));
      if (trust) lpf_mem = r.filt;
      return r;
   endfunction

   assign pending = torque_queue.size();

   always @(posedge clock) begin
      torque_set_t exp_t;
      int errs;
      errs = 0;
      if (reset) begin
         shadow_reg[REG_PITCH_FAILSAFE] = 52429;
         shadow_reg[REG_PITCH_REF_LIM] = 19661;
         shadow_reg[REG_VEL_GAIN] = 0;
         shadow_reg[REG_VEL_TRQ_LIM] = 65536;
         shadow_reg[REG_GRAV_GAIN] = 0;
         shadow_reg[REG_DAMP_GAIN] = 0;
         shadow_reg[REG_PITCH_GAIN] = 0;
         shadow_reg[REG_FILTER_ALPHA] = 0;
         lpf_mem = 0;
         torque_queue.delete();
         fail_count <= 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_PITCH_FAILSAFE, REG_FILTER_ALPHA:
                  shadow_reg[csr_index] = longint'(csr_wdata[16:0]);
               default:
                  shadow_reg[csr_index] = longint'(csr_wdata);
            endcase
         end
         // accepted input item
         if (req.valid && req.ready) begin
            torque_queue.push_back(torque_predict(
               longint'(req.pitch_meas), longint'(req.pitch_rate_meas),
               longint'(req.wheel_vel_meas), longint'(req.pitch_target),
               longint'(req.pitch_offset), longint'(req.vel_target),
               req.trust_update, req.filter_restart, longint'(req.filter_seed)));
         end
         // accepted result item
         if (rsp.valid && rsp.ready) begin
            if (torque_queue.size() == 0) begin
               $error("result item with no expected torque");
               errs++;
            end else begin
               exp_t = torque_queue.pop_front();
               if (longint'(rsp.mech_torque) != exp_t.mech) begin
                  $error("mech_torque expected %0d actual %0d", exp_t.mech, rsp.mech_torque);
                  errs++;
               end
               if (longint'(rsp.error_torque) != exp_t.err) begin
                  $error("error_torque expected %0d actual %0d", exp_t.err, rsp.error_torque);
                  errs++;
               end
               if (longint'(rsp.vel_torque) != exp_t.vel) begin
                  $error("vel_torque expected %0d actual %0d", exp_t.vel, rsp.vel_torque);
                  errs++;
               end
               if (longint'(rsp.raw_torque) != exp_t.raw) begin
                  $error("raw_torque expected %0d actual %0d", exp_t.raw, rsp.raw_torque);
                  errs++;
               end
               if (longint'(rsp.filtered_torque) != exp_t.filt) begin
                  $error("filtered_torque expected %0d actual %0d", exp_t.filt,
                         rsp.filtered_torque);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

// File: test/tb_top.sv
module tb_top;
   import bpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [22:0] csr_wdata;
   logic        calm;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   int          failures;

   bpd_req_if req ();
   bpd_rsp_if rsp ();

   balance_pd_torque_lpf_top dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   bpd_torque_checker torque_chk (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on cycles without any accepted item or register write
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side back-pressure in random bursts
   initial begin
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic reg_write(reg_index_type idx, logic [22:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic reg_write_done();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop the request, wait for every torque result, then settle
   task automatic quiesce();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Present one item; returns on the edge that accepts it
   task automatic send_torque_item(
      logic [23:0] pitch, logic [23:0] rate, logic [23:0] wheel, logic [23:0] target,
      logic [23:0] offset, logic [23:0] vref, logic trust, logic restart,
      logic [23:0] seed);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.pitch_meas      <= pitch;
      req.pitch_rate_meas <= rate;
      req.wheel_vel_meas  <= wheel;
      req.pitch_target    <= target;
      req.pitch_offset    <= offset;
      req.vel_target      <= vref;
      req.trust_update    <= trust;
      req.filter_restart  <= restart;
      req.filter_seed     <= seed;
      forever begin
         @(negedge clock);
         if (req.ready) break;
      end
      @(posedge clock);
   endtask

   function automatic logic [23:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'(int'($urandom_range(0, 400000)) - 200000);
         3: return 24'(int'($urandom_range(0, 20000)) - 10000);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [22:0] rand_reg(reg_index_type idx);
      logic [22:0] mask;
      mask = (idx == REG_PITCH_FAILSAFE || idx == REG_FILTER_ALPHA) ? 23'h1FFFF : 23'h7FFFFF;
      case ($urandom_range(0, 5))
         0: return 23'd0;
         1: return mask;
         2: return 23'($urandom()) & mask;
         default: return 23'($urandom_range(0, 200000)) & mask;
      endcase
   endfunction

   task automatic random_items(int count);
      repeat (count) begin
         send_torque_item(rand_field(), rand_field(), rand_field(), rand_field(),
                          rand_field(), rand_field(), 1'($urandom()), 1'($urandom()),
                          rand_field());
      end
   endtask

   task automatic random_config();
      for (int i = 0; i < 8; i++) reg_write(reg_index_type'(i), rand_reg(reg_index_type'(i)));
      reg_write_done();
   endtask

   initial begin
      reset      <= 1'b1;
      calm       <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= REG_PITCH_FAILSAFE;
      csr_wdata  <= '0;
      req.valid  <= 1'b0;
      req.pitch_meas      <= '0;
      req.pitch_rate_meas <= '0;
      req.wheel_vel_meas  <= '0;
      req.pitch_target    <= '0;
      req.pitch_offset    <= '0;
      req.vel_target      <= '0;
      req.trust_update    <= 1'b0;
      req.filter_restart  <= 1'b0;
      req.filter_seed     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset
      send_torque_item(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 24'd0);
      send_torque_item(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                       24'h7FFFFF, 1'b1, 1'b0, 24'h7FFFFF);
      quiesce();

      // moderate gains, failsafe above half pi, alpha half
      reg_write(REG_PITCH_FAILSAFE, 23'h1FFFF);
      reg_write(REG_PITCH_REF_LIM, 23'd40000);
      reg_write(REG_VEL_GAIN, 23'd131072);
      reg_write(REG_VEL_TRQ_LIM, 23'd200000);
      reg_write(REG_GRAV_GAIN, 23'd500000);
      reg_write(REG_DAMP_GAIN, 23'd30000);
      reg_write(REG_PITCH_GAIN, 23'd300000);
      reg_write(REG_FILTER_ALPHA, 23'd32768);
      reg_write_done();
      // pitch beyond failsafe both ways, at the half pi point, small angles
      send_torque_item(24'd200000, 24'd1000, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 24'd0);
      send_torque_item(-24'sd200000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 24'd0);
      send_torque_item(24'd102944, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 24'd0);
      send_torque_item(24'd1, -24'sd1, 24'd5, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 24'd0);
      // reference plus trim beyond its clamp and overflowing
      send_torque_item(24'd0, 24'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 1'b0, 1'b0, 24'd0);
      send_torque_item(24'd0, 24'd0, 24'd0, 24'h800000, 24'h800000, 24'd0, 1'b0, 1'b0, 24'd0);
      // velocity term past its clamp
      send_torque_item(24'd0, 24'd0, 24'h800000, 24'd0, 24'd0, 24'h7FFFFF, 1'b0, 1'b0, 24'd0);
      send_torque_item(24'd0, 24'd0, 24'h7FFFFF, 24'd0, 24'd0, 24'h800000, 1'b0, 1'b0, 24'd0);
      // restart without trust keeps the seed, then trust, then restart and trust
      send_torque_item(24'd5000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1, 24'h7FFFFF);
      send_torque_item(24'd5000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, 24'd0);
      send_torque_item(24'd5000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0, 24'd0);
      send_torque_item(-24'sd5000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1, 24'h800000);
      send_torque_item(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0, 24'd0);
      quiesce();

      // full scale gains, alpha above one, saturating sums
      reg_write(REG_PITCH_FAILSAFE, 23'd0);
      reg_write(REG_PITCH_REF_LIM, 23'h7FFFFF);
      reg_write(REG_VEL_GAIN, 23'h7FFFFF);
      reg_write(REG_VEL_TRQ_LIM, 23'h7FFFFF);
      reg_write(REG_GRAV_GAIN, 23'h7FFFFF);
      reg_write(REG_DAMP_GAIN, 23'h7FFFFF);
      reg_write(REG_PITCH_GAIN, 23'h7FFFFF);
      reg_write(REG_FILTER_ALPHA, 23'h1FFFF);
      reg_write_done();
      send_torque_item(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'd0, 24'h7FFFFF,
                       1'b1, 1'b1, 24'h123456);
      send_torque_item(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd0, 24'h800000,
                       1'b1, 1'b0, 24'd0);
      send_torque_item(24'd77, 24'd3, 24'd9, 24'd1, 24'd2, 24'd4, 1'b0, 1'b0, 24'd0);
      quiesce();

      // alpha exactly one and failsafe at its limit
      reg_write(REG_FILTER_ALPHA, 23'd65536);
      reg_write(REG_PITCH_FAILSAFE, 23'd102944);
      reg_write(REG_GRAV_GAIN, 23'd65536);
      reg_write_done();
      send_torque_item(24'd150000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1, 24'd4242);
      send_torque_item(-24'sd150000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0, 24'd0);
      quiesce();

      // random phases over random settings, the last without idling
      for (int ph = 0; ph < 5; ph++) begin
         random_config();
         if (ph == 4) calm <= 1'b1;
         random_items(80);
         quiesce();
      end

      failures = fail_count;
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/bpd_pkg.sv
rtl/bpd_req_if.sv
rtl/bpd_rsp_if.sv
rtl/balance_pd_torque_lpf_top.sv
test/bpd_torque_checker.sv
test/tb_top.sv
